[rtl/smm_pkg.sv]
// Shared types and constants for the systolic matrix multiply unit.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package smm_pkg;

  // Data path and port geometry
  localparam int DATA_W    = 32;
  localparam int LANES     = 4;
  localparam int IDX_W     = 2;
  localparam int CNT_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int SIDE_DEF  = 4;

  typedef logic [DATA_W-1:0]    word_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_ROWS_USED = 3'd0;
  localparam cfg_idx_t CFG_COLS_USED = 3'd1;
  localparam cfg_idx_t CFG_BIAS_ROW0 = 3'd2;
  localparam cfg_idx_t CFG_BIAS_ROW1 = 3'd3;
  localparam cfg_idx_t CFG_BIAS_ROW2 = 3'd4;
  localparam cfg_idx_t CFG_BIAS_ROW3 = 3'd5;

  // Array control: pulse moves operands one cell on, clear zeroes the array
  typedef struct packed {
    logic pulse;
    logic clear;
  } ctl_t;

endpackage

`default_nettype wire

[rtl/smm_skew.sv]
// Input skew delay line for one operand lane of the systolic array.
// Depends on smm_pkg (word_t, ctl_t).
`default_nettype none

module smm_skew #(
  parameter int DEPTH = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire smm_pkg::ctl_t ctl,
  input  wire smm_pkg::word_t din,
  output      smm_pkg::word_t dout
);
  import smm_pkg::*;

  word_t line_r [DEPTH];

  // Advance the line by one entry on each pulse
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < DEPTH; i++) line_r[i] <= '0;
    end else if (ctl.pulse) begin
      line_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) line_r[i] <= line_r[i-1];
    end
  end

  assign dout = line_r[DEPTH-1];

endmodule

`default_nettype wire

[rtl/smm_cell.sv]
// One multiply-accumulate cell of the output-stationary array.
// Depends on smm_pkg (word_t, ctl_t).
`default_nettype none

module smm_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire smm_pkg::ctl_t  ctl,
  input  wire smm_pkg::word_t a_in,
  input  wire smm_pkg::word_t b_in,
  output      smm_pkg::word_t a_out,
  output      smm_pkg::word_t b_out,
  output      smm_pkg::word_t sum
);
  import smm_pkg::*;

  word_t a_r, b_r, prod_r, sum_r;
  word_t prod_nxt;

  // Low word of the product; signed and unsigned agree there
  assign prod_nxt = word_t'(a_in * b_in);

  // Register the product, fold the previous one into the sum
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      a_r    <= '0;
      b_r    <= '0;
      prod_r <= '0;
      sum_r  <= '0;
    end else begin
      sum_r <= sum_r + prod_r;
      if (ctl.pulse) begin
        a_r    <= a_in;
        b_r    <= b_in;
        prod_r <= prod_nxt;
      end else begin
        prod_r <= '0;
      end
    end
  end

  assign a_out = a_r;
  assign b_out = b_r;
  assign sum   = sum_r;

endmodule

`default_nettype wire

[rtl/systolic_matrix_multiply_unit.sv]
// Top level of the systolic matrix multiply unit: skew lines, cell grid,
// sequencer, configuration registers. Depends on smm_pkg, smm_skew, smm_cell.
`default_nettype none

// Usage
//   Input: drive start with one inner-index step (column k of A on in_a_lane*,
//   row k of B on in_b_lane*); the beat is taken when start is high and busy
//   is low. Steps without in_last_step may follow back to back. Lanes at or
//   above SIDE are ignored.
//   The beat with in_last_step set ends the product: busy rises, the array
//   drains (ST_DRAIN), takes a final accumulate step (ST_FLUSH), and the
//   results follow in row-major order, one per cycle on out_valid,
//   rows_used*cols_used beats in all (counts clamped to 1..SIDE), out_last
//   on the final one. Each out_value is the cell sum plus that row's bias,
//   wrapped to 32 bits.
//   Throughput: one step per cycle while streaming; a product occupies the
//   block through the drain of the cell chain and the emission of its results
//   through the single result port; no new step is taken while busy is high.
//   Results are strobed for one cycle and cannot be held off.
//   Configuration: cfg_ready is always high; write only while busy is low.
//   Reset (rst_n low, synchronous) clears the array, sets both counts to 4
//   and the biases to 0.

module systolic_matrix_multiply_unit #(
  parameter int SIDE = smm_pkg::SIDE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic signed [smm_pkg::DATA_W-1:0] in_a_lane0,
  input  wire logic signed [smm_pkg::DATA_W-1:0] in_a_lane1,
  input  wire logic signed [smm_pkg::DATA_W-1:0] in_a_lane2,
  input  wire logic signed [smm_pkg::DATA_W-1:0] in_a_lane3,
  input  wire logic signed [smm_pkg::DATA_W-1:0] in_b_lane0,
  input  wire logic signed [smm_pkg::DATA_W-1:0] in_b_lane1,
  input  wire logic signed [smm_pkg::DATA_W-1:0] in_b_lane2,
  input  wire logic signed [smm_pkg::DATA_W-1:0] in_b_lane3,
  input  wire logic                          in_last_step,
  output      logic                          out_valid,
  output      logic [smm_pkg::IDX_W-1:0]     out_row,
  output      logic [smm_pkg::IDX_W-1:0]     out_col,
  output      logic signed [smm_pkg::DATA_W-1:0] out_value,
  output      logic                          out_last,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire smm_pkg::cfg_idx_t             cfg_index,
  input  wire smm_pkg::word_t                cfg_data
);
  import smm_pkg::*;

  localparam int   RW      = $clog2(SIDE);
  localparam int   DRAIN_N = 2*SIDE - 2;
  localparam int   DW      = $clog2(DRAIN_N);
  localparam cnt_t SIDE_CNT = cnt_t'(SIDE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  state_t          state_r;
  logic [DW-1:0]   drain_cnt_r;
  logic [RW-1:0]   row_cnt_r, col_cnt_r;
  logic [RW-1:0]   last_row, last_col;
  logic            accept, emit_done;
  ctl_t            ctl;

  cnt_t            rows_used_r, cols_used_r;
  word_t           bias_r [LANES];

  word_t           a_lane [LANES];
  word_t           b_lane [LANES];
  word_t           a_feed [SIDE];
  word_t           b_feed [SIDE];
  word_t           a_skew [SIDE];
  word_t           b_skew [SIDE];
  word_t           a_pass [SIDE][SIDE];
  word_t           b_pass [SIDE][SIDE];
  word_t           sum_w  [SIDE][SIDE];

  logic                 out_valid_r, out_last_r;
  logic [IDX_W-1:0]     out_row_r, out_col_r;
  word_t                out_value_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= cnt_t'(4);
      cols_used_r <= cnt_t'(4);
      for (int i = 0; i < LANES; i++) bias_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS_USED: rows_used_r <= cfg_data[CNT_W-1:0];
        CFG_COLS_USED: cols_used_r <= cfg_data[CNT_W-1:0];
        CFG_BIAS_ROW0: bias_r[0]   <= cfg_data;
        CFG_BIAS_ROW1: bias_r[1]   <= cfg_data;
        CFG_BIAS_ROW2: bias_r[2]   <= cfg_data;
        CFG_BIAS_ROW3: bias_r[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the counts to 1..SIDE and turn them into last indexes
  always_comb begin
    if (rows_used_r == '0)           last_row = '0;
    else if (rows_used_r > SIDE_CNT) last_row = RW'(SIDE - 1);
    else                             last_row = RW'(rows_used_r - cnt_t'(1));
    if (cols_used_r == '0)           last_col = '0;
    else if (cols_used_r > SIDE_CNT) last_col = RW'(SIDE - 1);
    else                             last_col = RW'(cols_used_r - cnt_t'(1));
  end

  // Array control
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign emit_done = (state_r == ST_EMIT) && (row_cnt_r == last_row) &&
                     (col_cnt_r == last_col);
  assign ctl.pulse = accept || (state_r == ST_DRAIN);
  assign ctl.clear = emit_done;

  // Gather the lanes, feed zeros while draining
  assign a_lane[0] = in_a_lane0;
  assign a_lane[1] = in_a_lane1;
  assign a_lane[2] = in_a_lane2;
  assign a_lane[3] = in_a_lane3;
  assign b_lane[0] = in_b_lane0;
  assign b_lane[1] = in_b_lane1;
  assign b_lane[2] = in_b_lane2;
  assign b_lane[3] = in_b_lane3;

  for (genvar r = 0; r < SIDE; r++) begin : g_lane
    assign a_feed[r] = accept ? a_lane[r] : '0;
    assign b_feed[r] = accept ? b_lane[r] : '0;
    if (r == 0) begin : g_direct
      assign a_skew[r] = a_feed[r];
      assign b_skew[r] = b_feed[r];
    end else begin : g_delay
      smm_skew #(.DEPTH(r)) u_a_skew (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .din(a_feed[r]), .dout(a_skew[r])
      );
      smm_skew #(.DEPTH(r)) u_b_skew (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .din(b_feed[r]), .dout(b_skew[r])
      );
    end
  end

  // Cell grid: a moves right, b moves down
  for (genvar r = 0; r < SIDE; r++) begin : g_row
    for (genvar c = 0; c < SIDE; c++) begin : g_col
      word_t a_cell, b_cell;
      if (c == 0) begin : g_a_edge
        assign a_cell = a_skew[r];
      end else begin : g_a_link
        assign a_cell = a_pass[r][c-1];
      end
      if (r == 0) begin : g_b_edge
        assign b_cell = b_skew[c];
      end else begin : g_b_link
        assign b_cell = b_pass[r-1][c];
      end
      smm_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .a_in(a_cell), .b_in(b_cell),
        .a_out(a_pass[r][c]), .b_out(b_pass[r][c]), .sum(sum_w[r][c])
      );
    end
  end

  // Sequencer: drain, flush the product stage, emit row-major
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drain_cnt_r <= '0;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_EMIT);
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_last_step) begin
            state_r     <= ST_DRAIN;
            drain_cnt_r <= '0;
          end
        end
        ST_DRAIN: begin
          drain_cnt_r <= drain_cnt_r + DW'(1);
          if (drain_cnt_r == DW'(DRAIN_N - 1)) state_r <= ST_FLUSH;
        end
        ST_FLUSH: begin
          state_r   <= ST_EMIT;
          row_cnt_r <= '0;
          col_cnt_r <= '0;
        end
        ST_EMIT: begin
          out_row_r   <= IDX_W'(row_cnt_r);
          out_col_r   <= IDX_W'(col_cnt_r);
          out_value_r <= sum_w[row_cnt_r][col_cnt_r] + bias_r[IDX_W'(row_cnt_r)];
          out_last_r  <= emit_done;
          if (emit_done) begin
            state_r <= ST_IDLE;
          end else if (col_cnt_r == last_col) begin
            col_cnt_r <= '0;
            row_cnt_r <= row_cnt_r + RW'(1);
          end else begin
            col_cnt_r <= col_cnt_r + RW'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  // Checks
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EMIT))
    else $error("result beat without an emit cycle");

  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_step) |=> busy)
    else $error("last step did not start the drain");

  a_results_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a result burst");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("still busy after the final result");

endmodule

`default_nettype wire
